// ===== sv/xbf_pkg.sv =====
// ----------------------------------------------------------------------------
// xbf_pkg
// shared types, constants and the crc step function of the block framer
// ----------------------------------------------------------------------------
package xbf_pkg;

	localparam int LONG_BLOCK_BYTES_DEF = 1024;
	localparam int SHORT_BLOCK_BYTES    = 128;
	localparam int QUEUE_DEPTH_DEF      = 2;

	localparam logic [7:0]  HDR_SHORT = 8'h01;
	localparam logic [7:0]  HDR_LONG  = 8'h02;
	localparam logic [15:0] CRC_POLY  = 16'h1021;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_BLOCKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_MODE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEVEN_BIT   = 2'd2;

	typedef struct packed {
		logic long_blocks;
		logic crc_mode;
		logic seven_bit;
	} cfg_t;

	// one classified input word, handed from front to back
	typedef struct packed {
		logic        first;
		logic        last;
		logic        hdr_long;
		logic        crc_mode;
		logic        seven_bit;
		logic [7:0]  blk;
		logic [7:0]  data;
		logic [15:0] chk;
	} job_t;

	// line byte slots of one job, in emission order
	typedef enum logic [2:0] {
		SLOT_HDR,
		SLOT_BLK,
		SLOT_INV,
		SLOT_DATA,
		SLOT_CHK_HI,
		SLOT_CHK_LO
	} slot_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/xbf_front.sv =====
// ----------------------------------------------------------------------------
// xbf_front
// accepts payload words, tracks block position and running crc / sum
// ----------------------------------------------------------------------------
module xbf_front #(
	parameter int LONG_BLOCK_BYTES = xbf_pkg::LONG_BLOCK_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [7:0]     data_byte,
	input  logic [7:0]     block_number,
	input  xbf_pkg::cfg_t  cfg,
	input  logic           q_full,
	output logic           q_push,
	output xbf_pkg::job_t  q_job
);

	localparam int PosW = $clog2(LONG_BLOCK_BYTES);
	localparam int LenW = PosW + 1;
	localparam logic [LenW-1:0] LongLen  = LenW'(LONG_BLOCK_BYTES);
	localparam logic [LenW-1:0] ShortLen = LenW'(xbf_pkg::SHORT_BLOCK_BYTES);

	logic [PosW-1:0] pos_q;
	logic [15:0]     crc_q;
	logic [7:0]      sum_q;

	logic            acc;
	logic            first;
	logic            last;
	logic [LenW-1:0] pos_next;
	logic [LenW-1:0] len;
	logic [15:0]     crc_new;
	logic [7:0]      sum_new;

	assign acc      = push && !q_full;
	assign first    = (pos_q == '0);
	assign pos_next = {1'b0, pos_q} + LenW'(1);
	assign len      = cfg.long_blocks ? LongLen : ShortLen;
	// a length change mid-block closes the block at once
	assign last     = (pos_next >= len);
	assign crc_new  = xbf_pkg::crc_feed(first ? 16'h0000 : crc_q, data_byte);
	assign sum_new  = (first ? 8'h00 : sum_q) + data_byte;

	always_comb begin
		q_push          = acc;
		q_job.first     = first;
		q_job.last      = last;
		q_job.hdr_long  = cfg.long_blocks;
		q_job.crc_mode  = cfg.crc_mode;
		q_job.seven_bit = cfg.seven_bit;
		q_job.blk       = block_number;
		q_job.data      = data_byte;
		q_job.chk       = cfg.crc_mode ? crc_new : {8'h00, sum_new};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= '0;
			sum_q <= '0;
		end else if (acc) begin
			if (last) begin
				pos_q <= '0;
				crc_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= pos_next[PosW-1:0];
				crc_q <= crc_new;
				sum_q <= sum_new;
			end
		end
	end

	a_pos_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last) |=> (pos_q == '0))
		else $error("block position not cleared after last word");

endmodule

// ===== sv/xbf_fifo.sv =====
// ----------------------------------------------------------------------------
// xbf_fifo
// short register queue of jobs between front and back
// ----------------------------------------------------------------------------
module xbf_fifo #(
	parameter int DEPTH = xbf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  xbf_pkg::job_t  wr_job,
	input  logic           rd,
	output xbf_pkg::job_t  rd_job,
	output logic           q_full,
	output logic           q_empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

	xbf_pkg::job_t   mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign q_full  = (count_q == DepthCnt);
	assign q_empty = (count_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rd_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DepthCnt)
		else $error("queue count beyond depth");

endmodule

// ===== sv/xbf_back.sv =====
// ----------------------------------------------------------------------------
// xbf_back
// walks the line byte slots of each job into the output register
// ----------------------------------------------------------------------------
module xbf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  xbf_pkg::job_t  head,
	input  logic           q_empty,
	output logic           q_pop,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     line_byte,
	output logic           frame_end
);

	logic           out_valid_q;
	logic [7:0]     line_byte_q;
	logic           frame_end_q;
	logic           active_q;
	xbf_pkg::slot_t slot_q;

	logic           active_d;
	xbf_pkg::slot_t slot_d;
	xbf_pkg::slot_t cur_slot;
	xbf_pkg::slot_t end_slot;
	logic           load;
	logic           at_end;
	logic [7:0]     raw_byte;
	logic [7:0]     out_byte;

	assign empty     = !out_valid_q;
	assign line_byte = line_byte_q;
	assign frame_end = frame_end_q;

	// output register takes a new word when free or being drained
	assign load = !q_empty && (!out_valid_q || pop);

	always_comb begin
		if (active_q) begin
			cur_slot = slot_q;
		end else if (head.first) begin
			cur_slot = xbf_pkg::SLOT_HDR;
		end else begin
			cur_slot = xbf_pkg::SLOT_DATA;
		end
		if (!head.last) begin
			end_slot = xbf_pkg::SLOT_DATA;
		end else if (head.crc_mode) begin
			end_slot = xbf_pkg::SLOT_CHK_LO;
		end else begin
			end_slot = xbf_pkg::SLOT_CHK_HI;
		end
		at_end = (cur_slot == end_slot);

		case (cur_slot)
			xbf_pkg::SLOT_HDR:    raw_byte = head.hdr_long ? xbf_pkg::HDR_LONG : xbf_pkg::HDR_SHORT;
			xbf_pkg::SLOT_BLK:    raw_byte = head.blk;
			xbf_pkg::SLOT_INV:    raw_byte = ~head.blk;
			xbf_pkg::SLOT_DATA:   raw_byte = head.data;
			// checksum mode keeps the sum in the low byte
			xbf_pkg::SLOT_CHK_HI: raw_byte = head.crc_mode ? head.chk[15:8] : head.chk[7:0];
			xbf_pkg::SLOT_CHK_LO: raw_byte = head.chk[7:0];
			default:              raw_byte = head.data;
		endcase
		out_byte = head.seven_bit ? {1'b0, raw_byte[6:0]} : raw_byte;

		q_pop    = load && at_end;
		active_d = active_q;
		slot_d   = slot_q;
		if (load) begin
			if (at_end) begin
				active_d = 1'b0;
			end else begin
				active_d = 1'b1;
				slot_d   = xbf_pkg::slot_t'(cur_slot + 3'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			slot_q      <= xbf_pkg::SLOT_HDR;
			out_valid_q <= 1'b0;
		end else begin
			active_q <= active_d;
			slot_q   <= slot_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			line_byte_q <= out_byte;
			frame_end_q <= at_end && head.last;
		end
	end

	a_active_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !q_empty)
		else $error("slot walk running with no job queued");

	a_last_job_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && head.last) |=> (frame_end_q && out_valid_q))
		else $error("last job retired without frame end word");

endmodule

// ===== sv/xmodem_block_framer_core.sv =====
// ----------------------------------------------------------------------------
// xmodem_block_framer_core
// frames payload bytes into xmodem / ymodem line bytes with crc or checksum
// ----------------------------------------------------------------------------
// usage:
//   input queue: drive data_byte and block_number with push; a word is taken
//   on a clock edge with push high and full low, one per cycle at most.
//   output queue: line_byte / frame_end are the oldest result while empty is
//   low; it is taken on a clock edge with pop high.
//   config: cfg_we writes bit 0 of cfg_data into register cfg_index
//   (0 long_blocks, 1 crc_mode, 2 seven_bit); other indexes are ignored.
// timing:
//   a taken word passes the job queue, then the output register. the back
//   end slot walk emits one line byte per cycle unless a low pop holds it;
//   a middle-of-block word gives one byte, the first word of a block four,
//   and the last word two (checksum) or three (crc).
// reset:
//   clears position, crc, sum and config and empties both queues.
// stall:
//   with pop low the output word holds, the job queue (two entries by
//   default) fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module xmodem_block_framer_core #(
	parameter int LONG_BLOCK_BYTES = xbf_pkg::LONG_BLOCK_BYTES_DEF,
	parameter int QUEUE_DEPTH      = xbf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    data_byte,
	input  logic [7:0]                    block_number,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    line_byte,
	output logic                          frame_end,
	input  logic                          cfg_we,
	input  logic [xbf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                          cfg_data
);

	xbf_pkg::cfg_t cfg_q;
	xbf_pkg::job_t push_job;
	xbf_pkg::job_t head_job;
	logic          q_push;
	logic          q_pop;
	logic          q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				xbf_pkg::CFG_LONG_BLOCKS: cfg_q.long_blocks <= cfg_data;
				xbf_pkg::CFG_CRC_MODE:    cfg_q.crc_mode    <= cfg_data;
				xbf_pkg::CFG_SEVEN_BIT:   cfg_q.seven_bit   <= cfg_data;
				default:                  cfg_q             <= cfg_q;
			endcase
		end
	end

	xbf_front #(
		.LONG_BLOCK_BYTES(LONG_BLOCK_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.data_byte    (data_byte),
		.block_number (block_number),
		.cfg          (cfg_q),
		.q_full       (full),
		.q_push       (q_push),
		.q_job        (push_job)
	);

	xbf_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_job  (push_job),
		.rd      (q_pop),
		.rd_job  (head_job),
		.q_full  (full),
		.q_empty (q_empty)
	);

	xbf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_job),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.line_byte (line_byte),
		.frame_end (frame_end)
	);

endmodule
